>>> sv/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies.
package bsc_pkg;

	localparam int DIV_W = 64;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_TEMP_TRIMS = 3'd0;
	localparam logic [IDX_W-1:0] REG_PRESS_LOW  = 3'd1;
	localparam logic [IDX_W-1:0] REG_PRESS_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] REG_PRESS_LAST = 3'd3;

	localparam logic [31:0] PRESS_SAT = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] nq;
		logic [DIV_W-1:0] dv;
		logic             neg;
		logic             nz;
	} div_t;

	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] centi;
	} temp_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

endpackage

>>> sv/baro_sensor_compensation.sv
// Top level of the barometric temperature and pressure compensation pipeline.
// Depends on bsc_pkg, bsc_mul64, bsc_div.
//
// Usage:
//  - A request (adc_temp, adc_press) is taken at each rising edge with start
//    high; busy is always low, so a new request may come every cycle.
//  - done pulses for one cycle with fine_temp, temp_centi, press_q24_8 and
//    press_valid for each accepted request, in request order. The receiver
//    cannot hold results off and none is needed: the pipeline never stalls.
//  - Throughput is one request per cycle. Latency is set mostly by the
//    64-cell division chain (one quotient bit per cell) plus the registered
//    64-bit multipliers of the polynomial stages.
//  - Trim registers are written through cfg_valid/cfg_ready/cfg_index/
//    cfg_data; cfg_ready is always high. Writes belong to idle periods.
//  - Reset clears the trim registers and all request valid flags; payload
//    in flight is dropped.
module baro_sensor_compensation (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [19:0]                 adc_temp,
	input  logic [19:0]                 adc_press,
	output logic                        done,
	output logic signed [31:0]          fine_temp,
	output logic signed [31:0]          temp_centi,
	output logic [31:0]                 press_q24_8,
	output logic                        press_valid,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bsc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [63:0]                 cfg_data
);

	localparam int LAST = 84;

	logic [47:0] temp_q;
	logic [63:0] plo_q;
	logic [63:0] phi_q;
	logic [15:0] p9_q;
	logic        vld_q [1:LAST];
	logic        done_q;

	logic [19:0] at_s1;
	logic [19:0] ap_q [1:10];

	logic signed [17:0] ta;
	logic signed [16:0] td;
	logic signed [15:0] t2s;
	logic signed [15:0] t3s;
	logic signed [33:0] ma;
	logic signed [33:0] dd;
	logic [31:0]        ma_s2;
	logic [31:0]        dd_s2;
	logic signed [19:0] xs;
	logic signed [35:0] mb;
	logic [31:0]        a_s3;
	logic [31:0]        mb_s3;
	logic [31:0]        fine_s4;
	logic [31:0]        c5;
	logic [63:0]        v1c;
	logic [63:0]        v1_s5;
	bsc_pkg::temp_t     sb_q [5:LAST];

	logic signed [49:0] r5c;
	logic signed [49:0] r2c;
	logic [63:0] r5_s6, r5_s7, r5_s8, r5_s9;
	logic [63:0] r2_s6, r2_s7, r2_s8, r2_s9;
	logic [63:0] q_s7;
	logic [63:0] qb_s9;
	logic [63:0] qc_s9;
	logic [63:0] v2_s10;
	logic [63:0] v1b_s10;
	logic [20:0] pp;
	logic [63:0] nm_s11;
	logic [63:0] u_s12;
	logic [63:0] u_s13;
	logic [63:0] e_s13;
	logic [63:0] dvc;
	bsc_pkg::div_t div_in;
	bsc_pkg::div_t div_in_s14;
	bsc_pkg::div_t div_out;

	logic [63:0] p_s79, p_s80, p_s81, p_s82, p_s83;
	logic        nz_q [79:LAST];
	logic [63:0] psc;
	logic [63:0] ps_s80, ps_s81;
	logic [63:0] f_s81;
	logic [63:0] g_s81;
	logic [63:0] h_s83;
	logic [63:0] w2_s82, w2_s83;
	logic [63:0] sum_s84;
	logic [63:0] pf;
	logic [31:0] press_c;

	logic [31:0] fine_q;
	logic [31:0] centi_q;
	logic [31:0] press_q;
	logic        pvalid_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// control and trims
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q <= '0;
			plo_q  <= '0;
			phi_q  <= '0;
			p9_q   <= '0;
			done_q <= 1'b0;
			for (int k = 1; k <= LAST; k++) vld_q[k] <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bsc_pkg::REG_TEMP_TRIMS: temp_q <= cfg_data[47:0];
					bsc_pkg::REG_PRESS_LOW:  plo_q  <= cfg_data;
					bsc_pkg::REG_PRESS_HIGH: phi_q  <= cfg_data;
					bsc_pkg::REG_PRESS_LAST: p9_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			vld_q[1] <= start && !busy;
			for (int k = 2; k <= LAST; k++) vld_q[k] <= vld_q[k-1];
			done_q <= vld_q[LAST];
		end
	end

	// temperature and pressure paths
	always_comb begin
		t2s = $signed(temp_q[31:16]);
		t3s = $signed(temp_q[47:32]);
		ta  = $signed({1'b0, at_s1[19:3]}) - $signed({1'b0, temp_q[15:0], 1'b0});
		td  = $signed({1'b0, at_s1[19:4]}) - $signed({1'b0, temp_q[15:0]});
		ma  = ta * t2s;
		dd  = td * td;
		xs  = 20'($signed(dd_s2) >>> 12);
		mb  = xs * t3s;
		c5  = fine_s4 * 32'd5 + 32'd128;
		v1c = {{32{fine_s4[31]}}, fine_s4} - 64'd128000;
		r5c = $signed(v1_s5[33:0]) * $signed(phi_q[15:0]);
		r2c = $signed(v1_s5[33:0]) * $signed(plo_q[31:16]);
		pp  = 21'd1048576 - {1'b0, ap_q[10]};
		dvc = $unsigned($signed(u_s13) >>> 33);
		div_in.rem = '0;
		div_in.nq  = e_s13[63] ? 64'd0 - e_s13 : e_s13;
		div_in.dv  = dvc[63] ? 64'd0 - dvc : dvc;
		div_in.neg = e_s13[63] ^ dvc[63];
		div_in.nz  = (dvc != 64'd0);
		psc = $unsigned($signed(p_s79) >>> 13);
		pf  = $unsigned($signed(sum_s84) >>> 8) + (bsc_pkg::sx16(phi_q[47:32]) << 4);
		if (!nz_q[LAST])
			press_c = 32'd0;
		else if (pf[63])
			press_c = 32'd0;
		else if (pf[63:32] != 32'd0)
			press_c = bsc_pkg::PRESS_SAT;
		else
			press_c = pf[31:0];
	end

	bsc_mul64 u_mul_a (.clk(clk), .a(v1_s5), .b(v1_s5), .p(q_s7));
	bsc_mul64 u_mul_b (.clk(clk), .a(q_s7), .b(bsc_pkg::sx16(phi_q[31:16])), .p(qb_s9));
	bsc_mul64 u_mul_c (.clk(clk), .a(q_s7), .b(bsc_pkg::sx16(plo_q[47:32])), .p(qc_s9));
	bsc_mul64 u_mul_d (
		.clk (clk),
		.a   (v1b_s10 + 64'h0000_8000_0000_0000),
		.b   ({48'd0, plo_q[15:0]}),
		.p   (u_s12)
	);
	bsc_mul64 u_mul_e (.clk(clk), .a(nm_s11), .b(64'd3125), .p(e_s13));
	bsc_mul64 u_mul_f (.clk(clk), .a(bsc_pkg::sx16(p9_q)), .b(psc), .p(f_s81));
	bsc_mul64 u_mul_g (.clk(clk), .a(bsc_pkg::sx16(phi_q[63:48])), .b(p_s79), .p(g_s81));
	bsc_mul64 u_mul_h (.clk(clk), .a(f_s81), .b(ps_s81), .p(h_s83));

	bsc_div u_div (
		.clk  (clk),
		.din  (div_in_s14),
		.dout (div_out)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		at_s1    <= adc_temp;
		ap_q[1]  <= adc_press;
		for (int k = 2; k <= 10; k++) ap_q[k] <= ap_q[k-1];
		ma_s2    <= ma[31:0];
		dd_s2    <= dd[31:0];
		a_s3     <= $unsigned($signed(ma_s2) >>> 11);
		mb_s3    <= mb[31:0];
		fine_s4  <= a_s3 + $unsigned($signed(mb_s3) >>> 14);
		sb_q[5].fine  <= fine_s4;
		sb_q[5].centi <= $unsigned($signed(c5) >>> 8);
		for (int k = 6; k <= LAST; k++) sb_q[k] <= sb_q[k-1];
		v1_s5    <= v1c;
		r5_s6    <= {{14{r5c[49]}}, r5c};
		r2_s6    <= {{14{r2c[49]}}, r2c};
		r5_s7    <= r5_s6;
		r5_s8    <= r5_s7;
		r5_s9    <= r5_s8;
		r2_s7    <= r2_s6;
		r2_s8    <= r2_s7;
		r2_s9    <= r2_s8;
		v2_s10   <= qb_s9 + (r5_s9 << 17) + (bsc_pkg::sx16(plo_q[63:48]) << 35);
		v1b_s10  <= $unsigned($signed(qc_s9) >>> 8) + (r2_s9 << 12);
		nm_s11   <= ({43'd0, pp} << 31) - v2_s10;
		u_s13    <= u_s12;
		div_in_s14 <= div_in;
		p_s79    <= div_out.neg ? 64'd0 - div_out.nq : div_out.nq;
		nz_q[79] <= div_out.nz;
		for (int k = 80; k <= LAST; k++) nz_q[k] <= nz_q[k-1];
		p_s80    <= p_s79;
		p_s81    <= p_s80;
		p_s82    <= p_s81;
		p_s83    <= p_s82;
		ps_s80   <= psc;
		ps_s81   <= ps_s80;
		w2_s82   <= $unsigned($signed(g_s81) >>> 19);
		w2_s83   <= w2_s82;
		sum_s84  <= p_s83 + $unsigned($signed(h_s83) >>> 25) + w2_s83;
		fine_q   <= sb_q[LAST].fine;
		centi_q  <= sb_q[LAST].centi;
		press_q  <= press_c;
		pvalid_q <= nz_q[LAST];
	end

	assign done        = done_q;
	assign fine_temp   = $signed(fine_q);
	assign temp_centi  = $signed(centi_q);
	assign press_q24_8 = press_q;
	assign press_valid = pvalid_q;

endmodule

>>> sv/bsc_mul64.sv
// Two-stage 64x64 multiplier, product modulo 2^64, built from 32x32 partial products.
// No dependencies.
module bsc_mul64 (
	input  logic        clk,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic [63:0] p
);

	logic [63:0] ll_q;
	logic [31:0] lh_q;
	logic [31:0] hl_q;
	logic [63:0] p_q;
	logic [63:0] lh_full;
	logic [63:0] hl_full;

	assign lh_full = a[31:0] * b[63:32];
	assign hl_full = a[63:32] * b[31:0];

	always_ff @(posedge clk) begin
		ll_q <= a[31:0] * b[31:0];
		lh_q <= lh_full[31:0];
		hl_q <= hl_full[31:0];
		p_q  <= ll_q + {lh_q + hl_q, 32'd0};
	end

	assign p = p_q;

endmodule

>>> sv/bsc_div_cell.sv
// One restoring-division cell: produces one quotient bit and hands the request on.
// Depends on bsc_pkg.
module bsc_div_cell (
	input  logic          clk,
	input  bsc_pkg::div_t din,
	output bsc_pkg::div_t dout
);

	logic [64:0]   t;
	logic [64:0]   sub;
	logic          ge;
	bsc_pkg::div_t nxt;
	bsc_pkg::div_t r_q;

	always_comb begin
		t   = {din.rem, din.nq[63]};
		sub = t - {1'b0, din.dv};
		ge  = (t >= {1'b0, din.dv});
		nxt = din;
		nxt.rem = ge ? sub[63:0] : t[63:0];
		nxt.nq  = {din.nq[62:0], ge};
	end

	always_ff @(posedge clk) begin
		r_q <= nxt;
	end

	assign dout = r_q;

endmodule

>>> sv/bsc_div.sv
// Chain of division cells, one quotient bit per cell, new request every cycle.
// Depends on bsc_pkg and bsc_div_cell.
module bsc_div (
	input  logic          clk,
	input  bsc_pkg::div_t din,
	output bsc_pkg::div_t dout
);

	bsc_pkg::div_t link [0:bsc_pkg::DIV_W];

	assign link[0] = din;

	for (genvar k = 0; k < bsc_pkg::DIV_W; k++) begin : g_cell
		bsc_div_cell u_cell (
			.clk  (clk),
			.din  (link[k]),
			.dout (link[k+1])
		);
	end

	assign dout = link[bsc_pkg::DIV_W];

endmodule

>>> tb/tb_top.sv
// Testbench for baro_sensor_compensation: drives raw reading pairs and trim writes,
// predicts each compensated result in SV and checks it against the done strobe.
// Depends on bsc_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb_top;
	import bsc_pkg::*;

	typedef struct packed {
		logic [31:0] fine;
		logic [31:0] centi;
		logic [31:0] press;
		logic        pvalid;
	} comp_res_t;

	logic clk, arst_n, start, busy, done, press_valid, cfg_valid, cfg_ready;
	logic [19:0] adc_temp, adc_press;
	logic signed [31:0] fine_temp, temp_centi;
	logic [31:0] press_q24_8;
	logic [IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	logic [47:0] temp_trims;
	logic [63:0] press_lo, press_hi;
	logic [15:0] press_last;
	comp_res_t pending_q[$];
	int errors;
	bit quiet;

	baro_sensor_compensation u_dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] s16(input logic [63:0] w, input int pos);
		logic [15:0] v;
		v = w[pos +: 16];
		return {{48{v[15]}}, v};
	endfunction

	function automatic comp_res_t compensate(input logic [19:0] at, input logic [19:0] ap);
		logic [31:0] t1, t2, t3, a, d, b, fine, dsh;
		logic signed [63:0] v1, v2, p, ps, w1, w2, x;
		logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, num, an, ad, q;
		comp_res_t r;
		t1 = {16'd0, temp_trims[15:0]};
		t2 = {{16{temp_trims[31]}}, temp_trims[31:16]};
		t3 = {{16{temp_trims[47]}}, temp_trims[47:32]};
		a = $signed((({12'd0, at} >> 3) - (t1 << 1)) * t2) >>> 11;
		d = ({12'd0, at} >> 4) - t1;
		dsh = $signed(d * d) >>> 12;
		b = $signed(dsh * t3) >>> 14;
		fine = a + b;
		r.fine = fine;
		r.centi = $signed(fine * 32'd5 + 32'd128) >>> 8;
		p1 = {48'd0, press_lo[15:0]};
		p2 = s16(press_lo, 16); p3 = s16(press_lo, 32); p4 = s16(press_lo, 48);
		p5 = s16(press_hi, 0); p6 = s16(press_hi, 16);
		p7 = s16(press_hi, 32); p8 = s16(press_hi, 48);
		p9 = s16({48'd0, press_last}, 0);
		v1 = {{32{fine[31]}}, fine} - 64'd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) << 17);
		v2 = v2 + (p4 << 35);
		x = $signed(v1 * v1 * p3) >>> 8;
		v1 = x + ((v1 * p2) << 12);
		v1 = $signed(((64'd1 << 47) + v1) * p1) >>> 33;
		r.press = 32'd0;
		r.pvalid = 1'b0;
		if (v1 != 0) begin
			p = 64'd1048576 - {44'd0, ap};
			num = ((p << 31) - v2) * 64'd3125;
			an = num[63] ? -num : num;
			ad = v1[63] ? -v1 : v1;
			q = an / ad;
			p = (num[63] != v1[63]) ? -q : q;
			ps = p >>> 13;
			w1 = $signed(p9 * ps * ps) >>> 25;
			w2 = $signed(p8 * p) >>> 19;
			x = (p + w1 + w2) >>> 8;
			p = x + (p7 << 4);
			if (p[63]) r.press = 32'd0;
			else if (p > 64'hFFFF_FFFF) r.press = PRESS_SAT;
			else r.press = p[31:0];
			r.pvalid = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] exp);
		errors++;
		$display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
	endtask

	always @(posedge clk) begin
		comp_res_t e;
		if (arst_n && done) begin
			if (pending_q.size() == 0) report_mismatch("unexpected result", 0, 0);
			else begin
				e = pending_q.pop_front();
				if (fine_temp !== e.fine) report_mismatch("fine_temp", fine_temp, e.fine);
				if (temp_centi !== e.centi) report_mismatch("temp_centi", temp_centi, e.centi);
				if (press_q24_8 !== e.press) report_mismatch("press_q24_8", press_q24_8, e.press);
				if (press_valid !== e.pvalid)
					report_mismatch("press_valid", press_valid, e.pvalid);
			end
		end
	end

	task automatic idle_gap();
		if (!quiet) while ($urandom_range(99) < 28) begin
			start <= 0;
			@(negedge clk);
		end
	endtask

	task automatic send_reading(input logic [19:0] at, input logic [19:0] ap);
		idle_gap();
		start <= 1; adc_temp <= at; adc_press <= ap;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_q.push_back(compensate(at, ap));
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 0;
		while (pending_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_trim(input logic [IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_TEMP_TRIMS: temp_trims = val[47:0];
			REG_PRESS_LOW:  press_lo = val;
			REG_PRESS_HIGH: press_hi = val;
			REG_PRESS_LAST: press_last = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	task automatic load_trims(input logic [63:0] t, lo, hi, last);
		drain();
		write_trim(REG_TEMP_TRIMS, t);
		write_trim(REG_PRESS_LOW, lo);
		write_trim(REG_PRESS_HIGH, hi);
		write_trim(REG_PRESS_LAST, last);
	endtask

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_zero_trims();
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
	endtask

	task automatic test_typical_trims();
		// typical factory calibration
		load_trims({16'h0000, 16'hFF9C, 16'h6892, 16'd27504},
			{16'hF7C2, 16'hD0FF, 16'h8F04, 16'd36477},
			{16'h3F5C, 16'hFFF9, 16'h008C, 16'h0000}, 64'd6000);
		send_reading(20'h7E1A0, 20'h655A0);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		send_reading(20'h80000, 20'h80000);
		send_reading(20'hFFFFF, 20'h00000);
		send_reading(20'h00000, 20'hFFFFF);
	endtask

	task automatic test_extreme_trims();
		load_trims(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_reading(20'h00000, 20'hFFFFF);
		send_reading(20'hFFFFF, 20'h00000);
		load_trims({16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF},
			{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF},
			{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, 64'h7FFF);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'hFFFFF);
		load_trims({16'h0000, 16'h8000, 16'h8000, 16'h0000},
			{16'h8000, 16'h8000, 16'h8000, 16'h0001},
			{16'h8000, 16'h8000, 16'h8000, 16'h8000}, 64'h8000);
		send_reading(20'h00000, 20'h00000);
		send_reading(20'hFFFFF, 20'h12345);
		// out-of-range index is ignored
		drain();
		write_trim(3'd5, 64'hDEAD_BEEF_DEAD_BEEF);
		write_trim(3'd7, 64'h1234_5678_9ABC_DEF0);
		send_reading(20'h55555, 20'hAAAAA);
	endtask

	task automatic test_random();
		logic [63:0] base_t, base_lo, base_hi;
		for (int ph = 0; ph < 10; ph++) begin
			base_t = rnd64(); base_lo = rnd64(); base_hi = rnd64();
			if (ph % 2 == 0) begin
				// realistic trims keep the divisor nonzero and the result in range
				base_t = {16'h0000, 16'hFF00 | base_t[39:32], 16'h6000 | base_t[27:16],
					16'h6000 | base_t[11:0]};
				base_lo = {16'h1000 | base_lo[59:48], 16'hD000 | base_lo[43:32],
					16'h8F00 | base_lo[23:16], 16'h8000 | base_lo[14:0]};
			end
			load_trims(base_t, base_lo, base_hi, rnd64());
			quiet = (ph == 4);
			for (int i = 0; i < 105; i++) begin
				if ($urandom_range(9) == 0)
					send_reading($urandom_range(1) ? 20'hFFFFF : 20'h0,
						$urandom_range(1) ? 20'hFFFFF : 20'h0);
				else
					send_reading(20'($urandom), 20'($urandom));
			end
			quiet = 0;
		end
	endtask

	initial begin
		errors = 0; quiet = 0;
		temp_trims = 0; press_lo = 0; press_hi = 0; press_last = 0;
		start = 0; adc_temp = 0; adc_press = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		arst_n = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		test_zero_trims();
		test_typical_trims();
		test_extreme_trims();
		test_random();
		drain();
		if (errors == 0 && pending_q.size() == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
